/* hw/rtl/ypbpr_pkg.sv */
`timescale 1ns / 1ps

package ypbpr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = 21;
    // signed weighted sum in units of 1e-6, |sum| <= 1e6 * 65535
    localparam int WSUM_W   = 37;
    // 1e6 * max_sample and all magnitudes and remainders
    localparam int DEN_W    = 36;
    // floor(mag * 2^17 / den) reaches 2^17
    localparam int QUO_W    = FRAC_W + 2;
    localparam int NUM_CH   = 3;

    localparam logic [SAMPLE_W-1:0] MAX_SAMPLE_RESET = 16'd255;
    localparam logic [19:0]         WEIGHT_ONE       = 20'd1000000;
    localparam logic [DEN_W-1:0]    DEN_RESET        = 36'd255000000;

    typedef logic [SAMPLE_W-1:0]        sample_t;
    typedef logic [DEN_W-1:0]           mag_t;
    typedef logic signed [WSUM_W-1:0]   wsum_t;
    typedef logic [QUO_W-1:0]           quo_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // rows: y, pb, pr; columns: red, green, blue
    localparam coef_t WEIGHT [NUM_CH][NUM_CH] = '{
        '{ 21'sd299000,  21'sd587000,  21'sd114000},
        '{-21'sd168736, -21'sd331264,  21'sd500000},
        '{ 21'sd500000, -21'sd418688, -21'sd81312}
    };

endpackage

/* hw/rtl/rgb_to_ypbpr_convert.sv */
// pipeline from an accepted input word to its output word
// (4 weighting stages, 18 divider stages at one quotient bit each, 1 output stage)
// throughput: one word per cycle; stalls hold each stage, empty stages fill up
// reset: pipeline emptied, max_sample returns to 255
`timescale 1ns / 1ps

module rgb_to_ypbpr_convert
    import ypbpr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [SAMPLE_W-1:0]     cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_W-1:0]     red_in,
    input  logic [SAMPLE_W-1:0]     green_in,
    input  logic [SAMPLE_W-1:0]     blue_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OUT_W-1:0]        luma,
    output logic signed [OUT_W-1:0] blue_diff,
    output logic signed [OUT_W-1:0] red_diff
);

    sample_t           max_sample_reg;
    sample_t           max_eff;
    mag_t              den_reg;
    mag_t              den_next;

    logic              wt_valid;
    logic              wt_stall;
    mag_t [NUM_CH-1:0] wt_mag;
    logic [NUM_CH-1:0] wt_neg;

    logic              div_valid;
    logic              div_stall;
    quo_t [NUM_CH-1:0] div_quo;
    logic [NUM_CH-1:0] div_neg;

    logic              out_valid_reg;
    logic              out_adv;
    logic [OUT_W-1:0]  res_reg  [NUM_CH];
    logic [OUT_W-1:0]  res_next [NUM_CH];
    quo_t              rnd      [NUM_CH];

    // a maximum of zero counts as one
    assign max_eff  = (max_sample_reg == '0) ? sample_t'(1) : max_sample_reg;
    assign den_next = DEN_W'(DEN_W'(max_eff) * DEN_W'(WEIGHT_ONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sample_reg <= MAX_SAMPLE_RESET;
            den_reg        <= DEN_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_sample_reg <= cfg_wr_data;
            end
            den_reg <= den_next;
        end
    end

    ypbpr_weight u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_eff   (max_eff),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (wt_valid),
        .out_stall (wt_stall),
        .mag       (wt_mag),
        .neg       (wt_neg)
    );

    ypbpr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .den       (den_reg),
        .in_valid  (wt_valid),
        .in_stall  (wt_stall),
        .mag       (wt_mag),
        .neg       (wt_neg),
        .out_valid (div_valid),
        .out_stall (div_stall),
        .quo       (div_quo),
        .quo_neg   (div_neg)
    );

    assign out_adv   = !out_valid_reg || !out_stall;
    assign div_stall = !out_adv;

    // quotient carries one extra fraction bit: add half and drop it
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rnd[c]      = div_quo[c] + quo_t'(1);
            res_next[c] = div_neg[c] ? -rnd[c][QUO_W-1:1] : rnd[c][QUO_W-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                res_reg[c] <= res_next[c];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign luma      = res_reg[0];
    assign blue_diff = $signed(res_reg[1]);
    assign red_diff  = $signed(res_reg[2]);

endmodule

/* hw/rtl/ypbpr_weight.sv */
`timescale 1ns / 1ps

module ypbpr_weight
    import ypbpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sample_t                  max_eff,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sample_t                  red_in,
    input  sample_t                  green_in,
    input  sample_t                  blue_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output mag_t [NUM_CH-1:0]        mag,
    output logic [NUM_CH-1:0]        neg
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;

    sample_t           samp_reg  [NUM_CH];
    sample_t           samp_next [NUM_CH];
    wsum_t             prod_reg  [NUM_CH][NUM_CH];
    wsum_t             prod_next [NUM_CH][NUM_CH];
    wsum_t             sum_reg   [NUM_CH];
    wsum_t             sum_next  [NUM_CH];
    wsum_t             sum_neg   [NUM_CH];
    mag_t              mag_reg   [NUM_CH];
    mag_t              mag_next  [NUM_CH];
    logic [NUM_CH-1:0] neg_reg;
    logic [NUM_CH-1:0] neg_next;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    always_comb
    begin
        // saturate samples to the maximum
        samp_next[0] = (red_in   > max_eff) ? max_eff : red_in;
        samp_next[1] = (green_in > max_eff) ? max_eff : green_in;
        samp_next[2] = (blue_in  > max_eff) ? max_eff : blue_in;

        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int j = 0; j < NUM_CH; j++)
            begin
                prod_next[c][j] =
                    $signed({{(WSUM_W - SAMPLE_W){1'b0}}, samp_reg[j]}) *
                    $signed({{(WSUM_W - COEF_W){WEIGHT[c][j][COEF_W-1]}}, WEIGHT[c][j]});
            end
            sum_next[c] = prod_reg[c][0] + prod_reg[c][1] + prod_reg[c][2];
            sum_neg[c]  = -sum_reg[c];
            neg_next[c] = sum_reg[c][WSUM_W-1];
            mag_next[c] = neg_next[c] ? sum_neg[c][DEN_W-1:0] : sum_reg[c][DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (adv[0])
            begin
                samp_reg[c] <= samp_next[c];
            end
            if (adv[1])
            begin
                for (int j = 0; j < NUM_CH; j++)
                begin
                    prod_reg[c][j] <= prod_next[c][j];
                end
            end
            if (adv[2])
            begin
                sum_reg[c] <= sum_next[c];
            end
            if (adv[3])
            begin
                mag_reg[c] <= mag_next[c];
                neg_reg[c] <= neg_next[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            mag[c] = mag_reg[c];
        end
    end

    assign neg = neg_reg;

endmodule

/* hw/rtl/ypbpr_div.sv */
`timescale 1ns / 1ps

module ypbpr_div
    import ypbpr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mag_t                     den,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  mag_t [NUM_CH-1:0]        mag,
    input  logic [NUM_CH-1:0]        neg,
    output logic                     out_valid,
    input  logic                     out_stall,
    output quo_t [NUM_CH-1:0]        quo,
    output logic [NUM_CH-1:0]        quo_neg
);

    // one quotient bit per stage, msb first
    localparam int STAGES = QUO_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   adv;

    mag_t              rem_reg [STAGES-1][NUM_CH];
    quo_t              quo_reg [STAGES][NUM_CH];
    logic [NUM_CH-1:0] neg_reg [STAGES];

    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            if (k == 0)
            begin
                valid_next[k] = in_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic [NUM_CH-1:0] neg_in;

        if (k == 0)
        begin : g_neg_first
            assign neg_in = neg;
        end
        else
        begin : g_neg_rest
            assign neg_in = neg_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                neg_reg[k] <= neg_in;
            end
        end

        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_ch
            logic [DEN_W:0] trial;
            logic [DEN_W:0] diff;
            logic           q_bit;
            quo_t           quo_prev;

            // first stage takes the magnitude as is, it never exceeds den
            if (k == 0)
            begin : g_first
                assign trial    = {1'b0, mag[c]};
                assign quo_prev = '0;
            end
            else
            begin : g_rest
                assign trial    = {rem_reg[k-1][c], 1'b0};
                assign quo_prev = quo_reg[k-1][c];
            end

            // trial < 2 * den, so the top bit of the difference is the borrow
            assign diff  = trial - {1'b0, den};
            assign q_bit = !diff[DEN_W];

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    quo_reg[k][c] <= {quo_prev[QUO_W-2:0], q_bit};
                end
            end

            if (k < STAGES - 1)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (adv[k])
                    begin
                        rem_reg[k][c] <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            quo[c] = quo_reg[STAGES-1][c];
        end
    end

    assign quo_neg = neg_reg[STAGES-1];

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
    import ypbpr_pkg::*;
();

    // bt.601 weights in units of 1e-6
    localparam longint Y_RED    = 299000;
    localparam longint Y_GREEN  = 587000;
    localparam longint Y_BLUE   = 114000;
    localparam longint PB_RED   = -168736;
    localparam longint PB_GREEN = -331264;
    localparam longint PB_BLUE  = 500000;
    localparam longint PR_RED   = 500000;
    localparam longint PR_GREEN = -418688;
    localparam longint PR_BLUE  = -81312;
    localparam longint UNIT     = 1000000;
    localparam int     LONG_HOLD_CYCLES = 300;

    typedef struct {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } rgb_word_t;

    typedef struct {
        logic [OUT_W-1:0]        y;
        logic signed [OUT_W-1:0] pb;
        logic signed [OUT_W-1:0] pr;
    } ypbpr_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [SAMPLE_W-1:0]     cfg_wr_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [SAMPLE_W-1:0]     red_in = '0;
    logic [SAMPLE_W-1:0]     green_in = '0;
    logic [SAMPLE_W-1:0]     blue_in = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [OUT_W-1:0]        luma;
    logic signed [OUT_W-1:0] blue_diff;
    logic signed [OUT_W-1:0] red_diff;

    rgb_word_t   pending_pixels[$];
    ypbpr_word_t expected_ypbpr[$];

    logic [SAMPLE_W-1:0] cur_max = MAX_SAMPLE_RESET;
    logic                in_taken = 1'b0;
    logic                calm = 1'b0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    int                  long_hold = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    int                  mismatch_count = 0;

    rgb_to_ypbpr_convert dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .luma        (luma),
        .blue_diff   (blue_diff),
        .red_diff    (red_diff)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("[rgb_to_ypbpr_convert] ERROR");
        $finish;
    end

    // weighted sum * 65536 / (1e6 * max), nearest, ties away from zero
    function automatic logic [OUT_W-1:0] round_scaled(longint num, longint dnm);
        longint mag;
        longint den;
        longint q;
        mag = (num < 0) ? -num : num;
        den = UNIT * dnm;
        q = (2 * mag * 65536 + den) / (2 * den);
        if (num < 0)
            q = -q;
        return q[OUT_W-1:0];
    endfunction

    function automatic ypbpr_word_t predict_ypbpr(rgb_word_t px, logic [SAMPLE_W-1:0] max_val);
        ypbpr_word_t res;
        longint d;
        longint r;
        longint g;
        longint b;
        d = (max_val == 0) ? 1 : max_val;
        r = px.red;
        g = px.green;
        b = px.blue;
        if (r > d)
            r = d;
        if (g > d)
            g = d;
        if (b > d)
            b = d;
        res.y  = round_scaled(Y_RED * r + Y_GREEN * g + Y_BLUE * b, d);
        res.pb = round_scaled(PB_RED * r + PB_GREEN * g + PB_BLUE * b, d);
        res.pr = round_scaled(PR_RED * r + PR_GREEN * g + PR_BLUE * b, d);
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_level(logic [SAMPLE_W-1:0] m);
        int unsigned mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: return '0;
            1: return m;
            2: return SAMPLE_W'($urandom_range(0, 65535));
            3: return (m < 16'hFFFF) ? SAMPLE_W'($urandom_range(int'(m) + 1, 65535))
                                     : 16'hFFFF;
            default: return SAMPLE_W'($urandom_range(0, int'(m)));
        endcase
    endfunction

    task automatic queue_pixel(int r, int g, int b);
        rgb_word_t w;
        w.red   = SAMPLE_W'(r);
        w.green = SAMPLE_W'(g);
        w.blue  = SAMPLE_W'(b);
        pending_pixels.push_back(w);
    endtask

    task automatic queue_random(int n);
        rgb_word_t w;
        for (int i = 0; i < n; i++)
        begin
            w.red   = pick_level(cur_max);
            w.green = pick_level(cur_max);
            w.blue  = pick_level(cur_max);
            pending_pixels.push_back(w);
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || in_valid || expected_ypbpr.size() != 0)
            @(posedge clk);
    endtask

    // only called with the pipeline empty
    task automatic write_max(logic [SAMPLE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_max = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin : pixel_driver
        logic      nxt_valid;
        rgb_word_t w;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (!(in_valid && !in_taken))
            begin
                nxt_valid = 1'b0;
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else if (pending_pixels.size() > 0)
                begin
                    w = pending_pixels.pop_front();
                    red_in   <= w.red;
                    green_in <= w.green;
                    blue_in  <= w.blue;
                    nxt_valid = 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 15);
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // receiver
    always @(negedge clk)
    begin : result_stall
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (rst_n)
        begin
            if (long_hold > 0)
            begin
                long_hold = long_hold - 1;
                nxt_stall = 1'b1;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                long_hold = LONG_HOLD_CYCLES - 1;
                nxt_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                nxt_stall = 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                nxt_stall = 1'b1;
            end
        end
        out_stall <= nxt_stall;
    end

    always @(posedge clk)
    begin : monitor
        rgb_word_t   px;
        ypbpr_word_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                px.red   = red_in;
                px.green = green_in;
                px.blue  = blue_in;
                expected_ypbpr.push_back(predict_ypbpr(px, cur_max));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_ypbpr.size() == 0)
                begin
                    $display("%0t: unexpected word y=%0d pb=%0d pr=%0d", $time,
                             luma, blue_diff, red_diff);
                    mismatch_count++;
                end
                else
                begin
                    e = expected_ypbpr.pop_front();
                    if (luma !== e.y)
                    begin
                        $display("%0t: luma expected %0d got %0d", $time, e.y, luma);
                        mismatch_count++;
                    end
                    if (blue_diff !== e.pb)
                    begin
                        $display("%0t: blue_diff expected %0d got %0d", $time, e.pb, blue_diff);
                        mismatch_count++;
                    end
                    if (red_diff !== e.pr)
                    begin
                        $display("%0t: red_diff expected %0d got %0d", $time, e.pr, red_diff);
                        mismatch_count++;
                    end
                end
            end
        end
        in_taken <= in_valid && !in_stall;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value of max_sample: corners, primaries, saturation
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(65535, 65535, 65535);
        queue_pixel(65535, 0, 0);
        queue_pixel(0, 65535, 0);
        queue_pixel(0, 0, 65535);
        queue_pixel(256, 0, 0);
        queue_pixel(254, 1, 128);
        wait_drained();

        write_max(16'hFFFF);
        queue_pixel(65535, 0, 0);
        queue_pixel(0, 65535, 0);
        queue_pixel(0, 0, 65535);
        queue_pixel(65535, 65535, 0);
        queue_pixel(0, 65535, 65535);
        queue_pixel(1, 1, 1);
        queue_pixel(32768, 32768, 32768);
        queue_pixel(43690, 21845, 52428);
        queue_random(150);
        wait_drained();

        write_max(16'd1);
        queue_random(150);
        wait_drained();

        // zero divisor acts as one
        write_max(16'd0);
        queue_random(150);
        wait_drained();

        // long receiver hold while the sender keeps offering words
        write_max(16'd255);
        queue_random(200);
        hold_req++;
        wait_drained();

        for (int i = 0; i < 4; i++)
        begin
            write_max(SAMPLE_W'($urandom_range(2, 65534)));
            queue_random(150);
            wait_drained();
        end

        write_max(16'd1023);
        queue_random(150);
        wait_drained();

        // back-to-back tail, no idling on either side
        calm = 1'b1;
        write_max(16'hFFFF);
        queue_random(200);
        wait_drained();

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("[rgb_to_ypbpr_convert] OK");
        else
            $display("[rgb_to_ypbpr_convert] ERROR");
        $finish;
    end

endmodule
